// ===== hw/rtl/grid_line_of_sight_assert.svh =====
// Assertion macros for the grid line-of-sight block.
// Used by the port checker; needs clk_i and rst_ni in the including scope.
`ifndef GRID_LINE_OF_SIGHT_ASSERT_SVH
`define GRID_LINE_OF_SIGHT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GLOS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line-of-sight port check failed");

// Next-cycle implication, checked outside reset
`define GLOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line-of-sight port check failed");

`endif

// ===== hw/rtl/glos_pkg.sv =====
// Shared types, constants and helper functions for the grid line-of-sight block.
// No dependencies; imported by every module of the block.
package glos_pkg;

  localparam int GridRows  = 64;
  localparam int GridCols  = 64;
  localparam int CoordW    = 6;
  localparam int CellW     = 8;
  localparam int MapDepth  = GridRows * GridCols;
  localparam int AddrW     = $clog2(MapDepth);
  // error term and its sum span (-major, 3*major], signed
  localparam int ErrW      = CoordW + 3;

  localparam logic [CellW-1:0] OpaqueReset = 8'd35;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef logic [CoordW-1:0]        coord_t;
  typedef logic [CellW-1:0]         cell_t;
  typedef logic [AddrW-1:0]         addr_t;
  typedef logic signed [ErrW-1:0]   err_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StSetup = 4'b0010,
    StWalk  = 4'b0100,
    StDrain = 4'b1000
  } walk_state_e;

  // read request from the walker to the map memory
  typedef struct packed {
    logic  re;
    addr_t addr;
  } rd_req_t;

  // one query result
  typedef struct packed {
    logic done;
    logic clear;
  } res_t;

  function automatic logic in_grid(coord_t row, coord_t col);
    logic row_ok;
    logic col_ok;
    row_ok = ({1'b0, row} < (CoordW + 1)'(GridRows));
    col_ok = ({1'b0, col} < (CoordW + 1)'(GridCols));
    return row_ok && col_ok;
  endfunction

  // row-major cell address
  function automatic addr_t cell_addr(coord_t row, coord_t col);
    return AddrW'(AddrW'(row) * AddrW'(GridCols) + AddrW'(col));
  endfunction

endpackage

// ===== hw/rtl/glos_map_ram.sv =====
// Map memory: one cell code per grid cell, one write and one read port.
// Depends on glos_pkg for widths and the read request type.
module glos_map_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  glos_pkg::addr_t   waddr_i,
  input  glos_pkg::cell_t   wdata_i,
  input  glos_pkg::rd_req_t rd_req_i,
  output glos_pkg::cell_t   rdata_o
);
  import glos_pkg::*;

  cell_t mem [MapDepth];
  cell_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_req_i.re) begin
      rdata_q <= mem[rd_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/glos_walker.sv =====
// Line walker: sequencer plus shared error-term adder stepping one cell per cycle.
// Depends on glos_pkg; reads cells through the map memory read port.
module glos_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  glos_pkg::coord_t  from_row_i,
  input  glos_pkg::coord_t  from_col_i,
  input  glos_pkg::coord_t  to_row_i,
  input  glos_pkg::coord_t  to_col_i,
  input  glos_pkg::cell_t   opaque_i,
  output glos_pkg::rd_req_t rd_req_o,
  input  glos_pkg::cell_t   rd_data_i,
  output logic              busy_o,
  output glos_pkg::res_t    res_o
);
  import glos_pkg::*;

  walk_state_e state_q, state_d;
  coord_t r0_q, c0_q, r1_q, c1_q;
  coord_t a_q, a_d, b_q, b_d, a1_q, a1_d;
  coord_t da_q, da_d, db_q, db_d;
  logic   bdown_q, bdown_d, steep_q, steep_d, first_q, first_d;
  err_t   err_q, err_d;
  logic   chk_q, blocked_q, blocked_d;
  res_t   res_q, res_d;

  // setup arithmetic
  coord_t dr, dc, sa0, sb0, sa1, sb1, a0, b0, a1, b1;
  logic   steep, swap;

  // walk arithmetic
  err_t   twice_db, twice_da, da_ext, err_sum;
  logic   step_minor;
  coord_t cur_row, cur_col;
  logic   hit;
  rd_req_t rd_req;

  // orient the line: pick the major axis, swap so the walk runs upward
  always_comb begin
    dr    = (r1_q >= r0_q) ? r1_q - r0_q : r0_q - r1_q;
    dc    = (c1_q >= c0_q) ? c1_q - c0_q : c0_q - c1_q;
    steep = dr > dc;
    sa0   = steep ? r0_q : c0_q;
    sb0   = steep ? c0_q : r0_q;
    sa1   = steep ? r1_q : c1_q;
    sb1   = steep ? c1_q : r1_q;
    swap  = sa0 > sa1;
    a0    = swap ? sa1 : sa0;
    b0    = swap ? sb1 : sb0;
    a1    = swap ? sa0 : sa1;
    b1    = swap ? sb0 : sb1;
  end

  // shared error-term adder and compare
  assign twice_db   = {2'b00, db_q, 1'b0};
  assign twice_da   = {2'b00, da_q, 1'b0};
  assign da_ext     = {3'b000, da_q};
  assign err_sum    = err_q + twice_db;
  assign step_minor = err_sum > da_ext;

  // current cell and its read request; endpoints are never read
  assign cur_row     = steep_q ? a_q : b_q;
  assign cur_col     = steep_q ? b_q : a_q;
  assign rd_req.re   = (state_q == StWalk) && !first_q && (a_q != a1_q) &&
                       in_grid(cur_row, cur_col);
  assign rd_req.addr = cell_addr(cur_row, cur_col);
  assign rd_req_o    = rd_req;

  // compare the cell read in the previous cycle
  assign hit = chk_q && (rd_data_i == opaque_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    a1_d      = a1_q;
    da_d      = da_q;
    db_d      = db_q;
    bdown_d   = bdown_q;
    steep_d   = steep_q;
    first_d   = first_q;
    err_d     = err_q;
    blocked_d = blocked_q | hit;
    res_d     = '{done: 1'b0, clear: res_q.clear};
    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        a_d       = a0;
        b_d       = b0;
        a1_d      = a1;
        da_d      = a1 - a0;
        db_d      = (b1 >= b0) ? b1 - b0 : b0 - b1;
        bdown_d   = b1 < b0;
        steep_d   = steep;
        first_d   = 1'b1;
        err_d     = '0;
        blocked_d = 1'b0;
        state_d   = StWalk;
      end
      StWalk: begin
        if (a_q == a1_q) begin
          state_d = StDrain;
        end else begin
          // advance along the major axis, step the minor axis past the half-way mark
          a_d     = a_q + 1'b1;
          first_d = 1'b0;
          if (step_minor) begin
            b_d   = bdown_q ? b_q - 1'b1 : b_q + 1'b1;
            err_d = err_sum - twice_da;
          end else begin
            err_d = err_sum;
          end
        end
      end
      StDrain: begin
        res_d   = '{done: 1'b1, clear: !(blocked_q || hit)};
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chk_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      chk_q   <= rd_req.re;
      res_q   <= res_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && go_i) begin
      r0_q <= from_row_i;
      c0_q <= from_col_i;
      r1_q <= to_row_i;
      c1_q <= to_col_i;
    end
    a_q         <= a_d;
    b_q         <= b_d;
    a1_q        <= a1_d;
    da_q        <= da_d;
    db_q        <= db_d;
    bdown_q     <= bdown_d;
    steep_q     <= steep_d;
    first_q     <= first_d;
    err_q       <= err_d;
    blocked_q   <= blocked_d;
  end

  assign busy_o = (state_q != StIdle);
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/grid_line_of_sight.sv =====
// Grid line-of-sight top level: command port, opaque-code register, map and walker.
// Depends on glos_pkg, glos_map_ram and glos_walker.
//
// A transaction is taken on start while busy is low. A map write (req_type_i = 0)
// completes in the cycle it is taken, raises no busy and gives no result. A sight
// query (req_type_i = 1) raises busy and gives exactly one result: done_o pulses for
// one cycle with sight_clear_o once the setup, walk and drain states have run. The
// walk reads one map cell per cycle along the major axis, the larger of the row and
// column distances, through the single memory read port; the next transaction may
// be given in the cycle that done_o pulses, so one query is in flight at a time. The
// result cannot be held off: it must be taken in the cycle done_o is high. Map
// contents are undefined after reset until written. The opaque code resets to 35
// and is written through the cfg channel while the block is not busy.
module grid_line_of_sight (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            req_type_i,
  input  glos_pkg::coord_t cell_row_i,
  input  glos_pkg::coord_t cell_col_i,
  input  glos_pkg::cell_t cell_code_i,
  input  glos_pkg::coord_t from_row_i,
  input  glos_pkg::coord_t from_col_i,
  input  glos_pkg::coord_t to_row_i,
  input  glos_pkg::coord_t to_col_i,
  output logic            done_o,
  output logic            sight_clear_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  glos_pkg::cell_t cfg_opaque_cell_i
);
  import glos_pkg::*;

  logic    accept;
  logic    query_go;
  logic    map_we;
  logic    walk_busy;
  cell_t   opaque_q;
  cell_t   rd_data;
  rd_req_t rd_req;
  res_t    res;

  // decode the accepted transaction
  assign accept   = start && !walk_busy;
  assign query_go = accept && (req_type_i == ReqQuery);
  assign map_we   = accept && (req_type_i == ReqWrite) && in_grid(cell_row_i, cell_col_i);

  // opaque-code register
  assign cfg_ready_o = !walk_busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opaque_q <= OpaqueReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      opaque_q <= cfg_opaque_cell_i;
    end
  end

  glos_map_ram u_map (
    .clk_i    (clk_i),
    .we_i     (map_we),
    .waddr_i  (cell_addr(cell_row_i, cell_col_i)),
    .wdata_i  (cell_code_i),
    .rd_req_i (rd_req),
    .rdata_o  (rd_data)
  );

  glos_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (query_go),
    .from_row_i (from_row_i),
    .from_col_i (from_col_i),
    .to_row_i   (to_row_i),
    .to_col_i   (to_col_i),
    .opaque_i   (opaque_q),
    .rd_req_o   (rd_req),
    .rd_data_i  (rd_data),
    .busy_o     (walk_busy),
    .res_o      (res)
  );

  assign busy          = walk_busy;
  assign done_o        = res.done;
  assign sight_clear_o = res.clear;

endmodule

// ===== hw/rtl/glos_checker.sv =====
// Port-level checker for the grid line-of-sight block, bound to the top level.
// Depends on grid_line_of_sight_assert.svh for the assertion macros.
`include "grid_line_of_sight_assert.svh"

module glos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic req_type_i,
  input logic done_o
);
  import glos_pkg::*;

  // a query transaction occupies the block
  `GLOS_ASSERT_NEXT(a_query_busy, start && !busy && (req_type_i == ReqQuery), busy)
  // a map write completes at once
  `GLOS_ASSERT_NEXT(a_write_free, start && !busy && (req_type_i == ReqWrite), !busy)
  // the result shows once the walk has finished
  `GLOS_ASSERT_NOW(a_done_idle, done_o, !busy)
  // each query ends in a result
  `GLOS_ASSERT_NOW(a_fall_done, $fell(busy), done_o)
  // the result strobe lasts one cycle
  `GLOS_ASSERT_NEXT(a_done_pulse, done_o, !done_o)

endmodule

bind grid_line_of_sight glos_checker u_glos_checker (.*);

// ===== sim/grid_line_of_sight_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the grid line-of-sight block: keeps its own copy of the map
// and the opaque code, predicts every sight query and compares each result.
// Depends on glos_pkg.
module grid_line_of_sight_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  logic             req_type_i,
  input  glos_pkg::coord_t cell_row_i,
  input  glos_pkg::coord_t cell_col_i,
  input  glos_pkg::cell_t  cell_code_i,
  input  glos_pkg::coord_t from_row_i,
  input  glos_pkg::coord_t from_col_i,
  input  glos_pkg::coord_t to_row_i,
  input  glos_pkg::coord_t to_col_i,
  input  logic             done_o,
  input  logic             sight_clear_o,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  glos_pkg::cell_t  cfg_opaque_cell_i,
  output int               mismatch_count,
  output int               results_pending
);
  import glos_pkg::*;

  typedef struct {
    coord_t fr;
    coord_t fc;
    coord_t tr;
    coord_t tc;
    logic   clear;
  } sight_answer_t;

  cell_t         grid_copy [MapDepth];
  cell_t         opaque_code;
  sight_answer_t awaited_sights [$];

  initial mismatch_count = 0;

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // cells off the grid never block
  function automatic bit cell_blocks(int row, int col);
    if (row < 0 || col < 0 || row >= GridRows || col >= GridCols) begin
      return 1'b0;
    end
    return grid_copy[row * GridCols + col] == opaque_code;
  endfunction

  // Walk the major axis upward; exact integer error term scaled by 2*major
  function automatic bit walk_line_clear(int r0, int c0, int r1, int c1);
    bit steep;
    int a0, b0, a1, b1, swap_tmp;
    int da, db, bstep, err, b;
    steep = iabs(r1 - r0) > iabs(c1 - c0);
    a0 = steep ? r0 : c0;
    b0 = steep ? c0 : r0;
    a1 = steep ? r1 : c1;
    b1 = steep ? c1 : r1;
    if (a0 > a1) begin
      swap_tmp = a0; a0 = a1; a1 = swap_tmp;
      swap_tmp = b0; b0 = b1; b1 = swap_tmp;
    end
    da    = a1 - a0;
    db    = iabs(b1 - b0);
    bstep = (b1 > b0) ? 1 : -1;
    err   = 0;
    b     = b0;
    for (int a = a0; a <= a1; a++) begin
      // endpoints are never tested
      if (a > a0 && a < a1) begin
        if (steep ? cell_blocks(a, b) : cell_blocks(b, a)) begin
          return 1'b0;
        end
      end
      err += 2 * db;
      if (err > da) begin
        b   += bstep;
        err -= 2 * da;
      end
    end
    return 1'b1;
  endfunction

  // Track every transaction at the clock edge that ends its cycle
  always @(posedge clk_i or negedge rst_ni) begin
    sight_answer_t ans;
    if (!rst_ni) begin
      opaque_code = OpaqueReset;
      awaited_sights.delete();
      results_pending = 0;
      foreach (grid_copy[i]) grid_copy[i] = '0;
    end else begin
      // compare the result before taking a new query in the same cycle
      if (done_o) begin
        if (awaited_sights.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result clear=%0b with no query outstanding", $realtime,
                     sight_clear_o);
          end
          mismatch_count++;
        end else begin
          ans = awaited_sights.pop_front();
          results_pending = awaited_sights.size();
          if (sight_clear_o !== ans.clear) begin
            if (mismatch_count < 10) begin
              $display("%0t: query (%0d,%0d)->(%0d,%0d) expected clear=%0b, got %0b",
                       $realtime, ans.fr, ans.fc, ans.tr, ans.tc, ans.clear,
                       sight_clear_o);
            end
            mismatch_count++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        opaque_code = cfg_opaque_cell_i;
      end

      if (start && !busy) begin
        if (req_type_i == ReqWrite) begin
          if (int'(cell_row_i) < GridRows && int'(cell_col_i) < GridCols) begin
            grid_copy[int'(cell_row_i) * GridCols + int'(cell_col_i)] = cell_code_i;
          end
        end else begin
          ans.fr    = from_row_i;
          ans.fc    = from_col_i;
          ans.tr    = to_row_i;
          ans.tc    = to_col_i;
          ans.clear = walk_line_clear(int'(from_row_i), int'(from_col_i),
                                      int'(to_row_i), int'(to_col_i));
          awaited_sights.push_back(ans);
          results_pending = awaited_sights.size();
        end
      end
    end
  end

endmodule

// ===== sim/grid_line_of_sight_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the grid line-of-sight block: writes map cells ahead of each
// query line, runs directed and random map writes and sight queries, gives the verdict.
// Depends on glos_pkg, grid_line_of_sight and grid_line_of_sight_checker.
module grid_line_of_sight_tb;
  import glos_pkg::*;

  localparam int LatencyCycles = 80;
  localparam int StallLimit    = 2000;
  localparam int ItemTarget    = 1250;
  localparam int PhaseCount    = 5;

  // terrain codes for the background; the reset opaque code is left out
  localparam cell_t TerrainCodes [16] = '{
    8'h00, 8'hFF, 8'h2E, 8'h41, 8'h7E, 8'h80, 8'h55, 8'hAA,
    8'h01, 8'hFE, 8'h10, 8'h5F, 8'h3A, 8'hC3, 8'h24, 8'h70
  };

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  logic   req_type_i = ReqWrite;
  coord_t cell_row_i = '0;
  coord_t cell_col_i = '0;
  cell_t  cell_code_i = '0;
  coord_t from_row_i = '0;
  coord_t from_col_i = '0;
  coord_t to_row_i = '0;
  coord_t to_col_i = '0;
  logic   done_o;
  logic   sight_clear_o;
  logic   cfg_valid_i = 1'b0;
  logic   cfg_ready_o;
  cell_t  cfg_opaque_cell_i = '0;
  int     mismatch_count;
  int     results_pending;

  cell_t  opaque_now = OpaqueReset;
  int     calm_left = 0;
  int     stall_cycles = 0;
  int     items_sent = 0;
  bit     cell_known [MapDepth];

  grid_line_of_sight dut (.*);

  grid_line_of_sight_checker line_checker (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > GridCols - 1) return coord_t'(GridCols - 1);
    return coord_t'(v);
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Hold start low for a drawn number of cycles, with stretches of none
  task automatic wait_gap(bit paced);
    int gap;
    gap = 0;
    if (paced) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = $urandom_range(10, 30);
      end else begin
        gap = $urandom_range(0, 12);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for the edge that takes the transaction; start stays high
  task automatic wait_accept();
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_map_write(coord_t row, coord_t col, cell_t code, bit paced);
    wait_gap(paced);
    start       <= 1'b1;
    req_type_i  <= ReqWrite;
    cell_row_i  <= row;
    cell_col_i  <= col;
    cell_code_i <= code;
    from_row_i  <= coord_t'($urandom);
    from_col_i  <= coord_t'($urandom);
    to_row_i    <= coord_t'($urandom);
    to_col_i    <= coord_t'($urandom);
    wait_accept();
    cell_known[int'(row) * GridCols + int'(col)] = 1'b1;
    items_sent++;
  endtask

  // Write terrain into every unwritten interior cell of a line before it is queried
  task automatic cover_line(int r0, int c0, int r1, int c1);
    bit steep;
    int a0, b0, a1, b1, swap_tmp;
    int da, db, bstep, err, b, row, col;
    steep = iabs(r1 - r0) > iabs(c1 - c0);
    a0 = steep ? r0 : c0;
    b0 = steep ? c0 : r0;
    a1 = steep ? r1 : c1;
    b1 = steep ? c1 : r1;
    if (a0 > a1) begin
      swap_tmp = a0; a0 = a1; a1 = swap_tmp;
      swap_tmp = b0; b0 = b1; b1 = swap_tmp;
    end
    da    = a1 - a0;
    db    = iabs(b1 - b0);
    bstep = (b1 > b0) ? 1 : -1;
    err   = 0;
    b     = b0;
    for (int a = a0; a <= a1; a++) begin
      if (a > a0 && a < a1) begin
        row = steep ? a : b;
        col = steep ? b : a;
        if (!cell_known[row * GridCols + col]) begin
          send_map_write(coord_t'(row), coord_t'(col),
                         TerrainCodes[$urandom_range(0, 15)], 1'b1);
        end
      end
      err += 2 * db;
      if (err > da) begin
        b   += bstep;
        err -= 2 * da;
      end
    end
  endtask

  task automatic send_sight_query(coord_t fr, coord_t fc, coord_t tr, coord_t tc);
    cover_line(int'(fr), int'(fc), int'(tr), int'(tc));
    wait_gap(1'b1);
    start       <= 1'b1;
    req_type_i  <= ReqQuery;
    cell_row_i  <= coord_t'($urandom);
    cell_col_i  <= coord_t'($urandom);
    cell_code_i <= cell_t'($urandom);
    from_row_i  <= fr;
    from_col_i  <= fc;
    to_row_i    <= tr;
    to_col_i    <= tc;
    wait_accept();
    items_sent++;
  endtask

  // Change the opaque code once the block has drained
  task automatic write_opaque(cell_t code);
    start <= 1'b0;
    @(posedge clk_i);
    wait (results_pending == 0);
    repeat (LatencyCycles) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_opaque_cell_i <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i       <= 1'b0;
    cfg_opaque_cell_i <= cell_t'($urandom);
    opaque_now = code;
  endtask

  initial begin
    int    kind;
    int    fr, fc;
    int    directed_items;
    int    phase_end;
    cell_t code;
    cell_t phase_codes [PhaseCount];

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset opaque code
    send_map_write(6'd0, 6'd31, OpaqueReset, 1'b1);
    send_sight_query(6'd0, 6'd0, 6'd0, 6'd63);     // full row, blocked mid-way
    send_sight_query(6'd0, 6'd31, 6'd0, 6'd63);    // opaque only at an endpoint
    send_sight_query(6'd0, 6'd63, 6'd0, 6'd0);     // reversed endpoints
    send_sight_query(6'd0, 6'd30, 6'd0, 6'd32);    // single interior cell
    send_sight_query(6'd0, 6'd31, 6'd0, 6'd32);    // adjacent points
    send_sight_query(6'd5, 6'd5, 6'd5, 6'd5);      // same point
    send_map_write(6'd40, 6'd63, OpaqueReset, 1'b1);
    send_sight_query(6'd0, 6'd63, 6'd63, 6'd63);   // full column, steep
    send_sight_query(6'd63, 6'd63, 6'd0, 6'd63);
    send_map_write(6'd20, 6'd20, OpaqueReset, 1'b1);
    send_sight_query(6'd0, 6'd0, 6'd63, 6'd63);    // diagonal tie, column leads
    send_sight_query(6'd63, 6'd63, 6'd0, 6'd0);
    send_sight_query(6'd10, 6'd20, 6'd30, 6'd21);  // steep, small minor step
    send_sight_query(6'd30, 6'd0, 6'd0, 6'd63);
    send_map_write(6'd63, 6'd0, 8'hFF, 1'b1);
    send_map_write(6'd0, 6'd63, 8'h00, 1'b1);
    send_sight_query(6'd63, 6'd0, 6'd0, 6'd63);    // anti-diagonal
    // error sum equal to the major delta must not step the minor axis
    send_map_write(6'd1, 6'd1, OpaqueReset, 1'b1);
    send_sight_query(6'd0, 6'd0, 6'd1, 6'd2);
    send_sight_query(6'd1, 6'd2, 6'd0, 6'd0);

    phase_codes[0] = 8'h00;
    phase_codes[1] = 8'hFF;
    phase_codes[2] = TerrainCodes[$urandom_range(2, 15)];
    phase_codes[3] = cell_t'($urandom);
    phase_codes[4] = OpaqueReset;

    // Random phases, each under its own opaque code, sharing the remaining items
    directed_items = items_sent;
    for (int p = 0; p < PhaseCount; p++) begin
      write_opaque(phase_codes[p]);
      phase_end = directed_items + (ItemTarget - directed_items) * (p + 1) / PhaseCount;
      while (items_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          code = ($urandom_range(0, 99) < 40) ? opaque_now :
                 ($urandom_range(0, 99) < 75) ? TerrainCodes[$urandom_range(0, 15)] :
                 cell_t'($urandom);
          send_map_write(coord_t'($urandom), coord_t'($urandom), code, 1'b1);
        end else begin
          fr = $urandom_range(0, 63);
          fc = $urandom_range(0, 63);
          kind = $urandom_range(0, 99);
          if (kind < 10) begin
            // equal or adjacent points
            send_sight_query(coord_t'(fr), coord_t'(fc),
                             clamp_coord(fr + $urandom_range(0, 2) - 1),
                             clamp_coord(fc + $urandom_range(0, 2) - 1));
          end else if (kind < 75) begin
            send_sight_query(coord_t'(fr), coord_t'(fc),
                             clamp_coord(fr + $urandom_range(0, 16) - 8),
                             clamp_coord(fc + $urandom_range(0, 16) - 8));
          end else begin
            send_sight_query(coord_t'(fr), coord_t'(fc),
                             coord_t'($urandom), coord_t'($urandom));
          end
        end
      end
    end

    // Drain and give the verdict
    start <= 1'b0;
    @(posedge clk_i);
    wait (results_pending == 0);
    repeat (LatencyCycles) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/glos_pkg.sv
hw/rtl/glos_map_ram.sv
hw/rtl/glos_walker.sv
hw/rtl/grid_line_of_sight.sv
hw/rtl/glos_checker.sv
sim/grid_line_of_sight_checker.sv
sim/grid_line_of_sight_tb.sv
